@@ rtl/cnmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cnmt_pkg;

	// search horizon in calendar years past the start year
	localparam int unsigned HORIZON_YEARS = 8;
	localparam int unsigned YEAR_CAP      = 4096;

	localparam int unsigned MINUTE_W  = 60;
	localparam int unsigned HOUR_W    = 24;
	localparam int unsigned MDAY_W    = 31;
	localparam int unsigned MONTH_W   = 12;
	localparam int unsigned WDAY_W    = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 60;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MINUTE_MASK  = 3'd0,
		CFG_HOUR_MASK    = 3'd1,
		CFG_MDAY_MASK    = 3'd2,
		CFG_MONTH_MASK   = 3'd3,
		CFG_WEEKDAY_MASK = 3'd4
	} cnmt_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_PREP,
		ST_ROUND,
		ST_SEARCH
	} cnmt_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic reduce;
		logic prep;
		logic round;
		logic step;
		logic load_out;
	} cnmt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic reduce_done;
		logic finished;
	} cnmt_status_t;

	// calendar position of the search
	typedef struct packed {
		logic [12:0] year;
		logic [11:0] ymod;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  wday;
	} cnmt_cal_t;

	// Gregorian leap year from the two low year bits and the year mod 400
	function automatic logic is_leap(input logic [1:0] ylow, input logic [11:0] ymod);
		return (ylow == 2'd0) && (ymod != 12'd100) && (ymod != 12'd200) &&
			(ymod != 12'd300);
	endfunction

	function automatic logic [4:0] days_in(input logic leap, input logic [3:0] month);
		logic [4:0] len;
		unique case (month)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// remainder by seven of a small value, one compare and subtract per step
	function automatic logic [2:0] mod7(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		for (int i = 0; i < 5; i++) begin
			if (r >= 6'd7) r = r - 6'd7;
		end
		return r[2:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/cnmt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// start time channel
interface cnmt_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] start_year;
	logic [3:0]  start_month;
	logic [4:0]  start_day;
	logic [4:0]  start_hour;
	logic [5:0]  start_minute;
	logic [5:0]  start_second;
	logic [2:0]  start_weekday;

	modport source (output valid, start_year, start_month, start_day, start_hour,
		start_minute, start_second, start_weekday, input ready);
	modport sink (input valid, start_year, start_month, start_day, start_hour,
		start_minute, start_second, start_weekday, output ready);
endinterface

// match result channel
interface cnmt_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [11:0] run_year;
	logic [3:0]  run_month;
	logic [4:0]  run_day;
	logic [4:0]  run_hour;
	logic [5:0]  run_minute;
	logic [2:0]  run_weekday;

	modport source (output valid, found, run_year, run_month, run_day, run_hour,
		run_minute, run_weekday, input ready);
	modport sink (input valid, found, run_year, run_month, run_day, run_hour,
		run_minute, run_weekday, output ready);
endinterface

// configuration write channel
interface cnmt_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [cnmt_pkg::CFG_IDX_W-1:0]     index;
	logic [cnmt_pkg::CFG_DAT_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/cnmt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cnmt_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start_valid,
	output logic                        start_ready,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	input  wire cnmt_pkg::cnmt_status_t status,
	output cnmt_pkg::cnmt_cmd_t         cmd
);

	cnmt_pkg::cnmt_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  slot_free;

	assign slot_free    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cnmt_pkg::ST_IDLE:   if (start_valid) state_d = cnmt_pkg::ST_REDUCE;
			cnmt_pkg::ST_REDUCE: if (status.reduce_done) state_d = cnmt_pkg::ST_PREP;
			cnmt_pkg::ST_PREP:   state_d = cnmt_pkg::ST_ROUND;
			cnmt_pkg::ST_ROUND:  state_d = cnmt_pkg::ST_SEARCH;
			cnmt_pkg::ST_SEARCH: if (status.finished && slot_free) state_d = cnmt_pkg::ST_IDLE;
			default:             state_d = cnmt_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd         = '0;
		start_ready = 1'b0;
		unique case (state_q)
			cnmt_pkg::ST_IDLE: begin
				start_ready = 1'b1;
				cmd.load    = start_valid;
			end
			cnmt_pkg::ST_REDUCE: cmd.reduce = !status.reduce_done;
			cnmt_pkg::ST_PREP:   cmd.prep = 1'b1;
			cnmt_pkg::ST_ROUND:  cmd.round = 1'b1;
			cnmt_pkg::ST_SEARCH: begin
				cmd.step     = !status.finished;
				cmd.load_out = status.finished && slot_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the result until taken; a new load wins over a take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/cnmt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cnmt_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cnmt_pkg::cnmt_cmd_t           cmd,
	output cnmt_pkg::cnmt_status_t             status,
	input  wire logic [11:0]                   start_year,
	input  wire logic [3:0]                    start_month,
	input  wire logic [4:0]                    start_day,
	input  wire logic [4:0]                    start_hour,
	input  wire logic [5:0]                    start_minute,
	input  wire logic [5:0]                    start_second,
	input  wire logic [2:0]                    start_weekday,
	input  wire logic                          cfg_we,
	input  wire logic [cnmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cnmt_pkg::CFG_DAT_W-1:0] cfg_data,
	output logic                               found,
	output logic [11:0]                        run_year,
	output logic [3:0]                         run_month,
	output logic [4:0]                         run_day,
	output logic [4:0]                         run_hour,
	output logic [5:0]                         run_minute,
	output logic [2:0]                         run_weekday
);

	logic [cnmt_pkg::MINUTE_W-1:0] minute_mask_q;
	logic [cnmt_pkg::HOUR_W-1:0]   hour_mask_q;
	logic [cnmt_pkg::MDAY_W-1:0]   mday_mask_q;
	logic [cnmt_pkg::MONTH_W-1:0]  month_mask_q;
	logic [cnmt_pkg::WDAY_W-1:0]   wday_mask_q;

	cnmt_pkg::cnmt_cal_t cur_q, nm, nd, nh, cal_d;
	logic [12:0]         limit_q;
	logic                sec_nz_q;

	logic [4:0]  dim;
	logic [12:0] limit_raw;
	logic        month_ok, dom, dow, dom_wild, dow_wild, day_ok;
	logic [cnmt_pkg::HOUR_W-1:0]   hr_masked;
	logic [cnmt_pkg::MINUTE_W-1:0] mn_masked;
	logic        hr_any, mn_any, hit, exhausted;
	logic [4:0]  hr_idx;
	logic [5:0]  mn_idx;
	logic [3:0]  wd_cnt;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minute_mask_q <= '1;
			hour_mask_q   <= '1;
			mday_mask_q   <= '1;
			month_mask_q  <= '1;
			wday_mask_q   <= 8'h7F;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cnmt_pkg::CFG_MINUTE_MASK:  minute_mask_q <= cfg_data[cnmt_pkg::MINUTE_W-1:0];
				cnmt_pkg::CFG_HOUR_MASK:    hour_mask_q   <= cfg_data[cnmt_pkg::HOUR_W-1:0];
				cnmt_pkg::CFG_MDAY_MASK:    mday_mask_q   <= cfg_data[cnmt_pkg::MDAY_W-1:0];
				cnmt_pkg::CFG_MONTH_MASK:   month_mask_q  <= cfg_data[cnmt_pkg::MONTH_W-1:0];
				cnmt_pkg::CFG_WEEKDAY_MASK: wday_mask_q   <= cfg_data[cnmt_pkg::WDAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign dim = cnmt_pkg::days_in(cnmt_pkg::is_leap(cur_q.year[1:0], cur_q.ymod), cur_q.month);

	// advance to the first minute of the next month
	always_comb begin
		nm        = cur_q;
		nm.wday   = cnmt_pkg::mod7(6'(cur_q.wday) + 6'(dim) - 6'(cur_q.day) + 6'd1);
		nm.day    = 5'd1;
		nm.hour   = 5'd0;
		nm.minute = 6'd0;
		if (cur_q.month >= 4'd12) begin
			nm.month = 4'd1;
			nm.year  = cur_q.year + 13'd1;
			nm.ymod  = (cur_q.ymod == 12'd399) ? 12'd0 : cur_q.ymod + 12'd1;
		end else begin
			nm.month = cur_q.month + 4'd1;
		end
	end

	// advance to the next day
	always_comb begin
		if (cur_q.day >= dim) begin
			nd = nm;
		end else begin
			nd        = cur_q;
			nd.wday   = (cur_q.wday >= 3'd6) ? 3'd0 : cur_q.wday + 3'd1;
			nd.day    = cur_q.day + 5'd1;
			nd.hour   = 5'd0;
			nd.minute = 6'd0;
		end
	end

	// advance to the next hour
	always_comb begin
		if (cur_q.hour >= 5'd23) begin
			nh = nd;
		end else begin
			nh        = cur_q;
			nh.hour   = cur_q.hour + 5'd1;
			nh.minute = 6'd0;
		end
	end

	// match tests on the current position
	always_comb begin
		wd_cnt   = 4'($countones(wday_mask_q));
		month_ok = month_mask_q[4'(cur_q.month - 4'd1)];
		dom_wild = (mday_mask_q == '1);
		dow_wild = (wd_cnt == 4'd7) || (wd_cnt == 4'd8);
		dom      = mday_mask_q[5'(cur_q.day - 5'd1)];
		dow      = wday_mask_q[cur_q.wday] || ((cur_q.wday == 3'd0) && wday_mask_q[7]);
		if (dom_wild && dow_wild) day_ok = 1'b1;
		else if (dom_wild)        day_ok = dow;
		else if (dow_wild)        day_ok = dom;
		else                      day_ok = dom || dow;
	end

	// first matching hour and minute at or after the current ones
	always_comb begin
		hr_masked = hour_mask_q & ({cnmt_pkg::HOUR_W{1'b1}} << cur_q.hour);
		mn_masked = minute_mask_q & ({cnmt_pkg::MINUTE_W{1'b1}} << cur_q.minute);
		hr_any    = |hr_masked;
		mn_any    = |mn_masked;
		hr_idx    = 5'd0;
		mn_idx    = 6'd0;
		for (int i = cnmt_pkg::HOUR_W - 1; i >= 0; i--) begin
			if (hr_masked[i]) hr_idx = 5'(i);
		end
		for (int i = cnmt_pkg::MINUTE_W - 1; i >= 0; i--) begin
			if (mn_masked[i]) mn_idx = 6'(i);
		end
	end

	assign exhausted = (cur_q.year >= limit_q);
	assign hit       = !exhausted && month_ok && day_ok && hr_any && (hr_idx == cur_q.hour) &&
		mn_any;

	assign status.finished    = exhausted || hit;
	assign status.reduce_done = (cur_q.ymod < 12'd400);

	assign limit_raw = 13'(start_year) + 13'(cnmt_pkg::HORIZON_YEARS);

	// next position
	always_comb begin
		cal_d = cur_q;
		if (cmd.load) begin
			cal_d.year   = 13'(start_year);
			cal_d.ymod   = start_year;
			cal_d.month  = (start_month == 4'd0) ? 4'd1 :
				(start_month > 4'd12) ? 4'd12 : start_month;
			cal_d.day    = start_day;
			cal_d.hour   = (start_hour > 5'd23) ? 5'd23 : start_hour;
			cal_d.minute = (start_minute > 6'd59) ? 6'd59 : start_minute;
			cal_d.wday   = (start_weekday == 3'd7) ? 3'd0 : start_weekday;
		end else if (cmd.reduce) begin
			cal_d.ymod = cur_q.ymod - 12'd400;
		end else if (cmd.prep) begin
			if (cur_q.day == 5'd0) cal_d.day = 5'd1;
			else if (cur_q.day > dim) cal_d.day = dim;
		end else if (cmd.round) begin
			if (sec_nz_q) begin
				if (cur_q.minute >= 6'd59) cal_d = nh;
				else cal_d.minute = cur_q.minute + 6'd1;
			end
		end else if (cmd.step && !exhausted) begin
			priority if (!month_ok) begin
				cal_d = nm;
			end else if (!day_ok || !hr_any) begin
				cal_d = nd;
			end else if (hr_idx != cur_q.hour) begin
				cal_d.hour   = hr_idx;
				cal_d.minute = 6'd0;
			end else if (!mn_any) begin
				cal_d = nh;
			end else begin
				cal_d.minute = mn_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cal_d;
		if (cmd.load) begin
			sec_nz_q <= (start_second != 6'd0);
			limit_q  <= (limit_raw > 13'(cnmt_pkg::YEAR_CAP)) ? 13'(cnmt_pkg::YEAR_CAP) :
				limit_raw;
		end
	end

	// capture the result; all fields zero when nothing matched
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found       <= hit;
			run_year    <= hit ? cur_q.year[11:0] : 12'd0;
			run_month   <= hit ? cur_q.month : 4'd0;
			run_day     <= hit ? cur_q.day : 5'd0;
			run_hour    <= hit ? cur_q.hour : 5'd0;
			run_minute  <= hit ? mn_idx : 6'd0;
			run_weekday <= hit ? cur_q.wday : 3'd0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/cron_next_match_time.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Next cron match search.
// The start channel takes one UTC start time per item; the result channel gives one
// item per start: found plus the first whole minute at or after it that matches the
// minute, hour, day-of-month, month and weekday masks, all zero when none lies within
// the year horizon. The cfg channel writes the masks by index; it is always ready and
// is meant to be used only while no search is in flight.
// Sequence: the item is taken in IDLE, REDUCE brings the year mod 400 down by repeated
// subtraction, PREP clamps the day and ROUND rounds up the seconds, then one search step
// per cycle; the result is registered once the search finishes and the register is free.
// A step skips a month, skips a day, jumps to the next matching hour, or finishes the
// hour; a search takes from one step per skipped month up to one step per hour it
// passes, the worst case over the horizon being when no minute matches.
// One item is searched at a time.
// The result sits in an output register: a new start is taken while it waits, and a
// finished search holds until the register is free. Reset clears the control state,
// sets every mask to its wildcard and leaves the result channel empty.

module cron_next_match_time (
	input  wire logic clk,
	input  wire logic arst_n,
	cnmt_in_if.sink   start,
	cnmt_out_if.source result,
	cnmt_cfg_if.sink  cfg
);

	cnmt_pkg::cnmt_cmd_t    cmd;
	cnmt_pkg::cnmt_status_t status;

	assign cfg.ready = 1'b1;

	cnmt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_valid  (start.valid),
		.start_ready  (start.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	cnmt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.start_year    (start.start_year),
		.start_month   (start.start_month),
		.start_day     (start.start_day),
		.start_hour    (start.start_hour),
		.start_minute  (start.start_minute),
		.start_second  (start.start_second),
		.start_weekday (start.start_weekday),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.found         (result.found),
		.run_year      (result.run_year),
		.run_month     (result.run_month),
		.run_day       (result.run_day),
		.run_hour      (result.run_hour),
		.run_minute    (result.run_minute),
		.run_weekday   (result.run_weekday)
	);

endmodule

`default_nettype wire

@@ verif/tb_cron_next_match_time.sv @@
`timescale 1ns / 1ps

module tb_cron_next_match_time;

	localparam int WATCHDOG_CYCLES = 500000;
	localparam int LONG_STALL      = 400;
	localparam int SETTLE_CYCLES   = 20;
	localparam int IDLE_PERCENT    = 7;
	localparam logic [cnmt_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  wday;
	} start_t;

	typedef struct packed {
		logic        found;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  wday;
	} match_t;

	// pending calendar move of the search
	typedef enum int {ADV_NONE, ADV_HOUR, ADV_DAY, ADV_MONTH} advance_t;

	logic clk;
	logic arst_n;

	cnmt_in_if  start_ch ();
	cnmt_out_if result_ch ();
	cnmt_cfg_if cfg_ch ();

	cron_next_match_time dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// mask copies as the block should hold them
	logic [59:0] minute_bits;
	logic [23:0] hour_bits;
	logic [30:0] mday_bits;
	logic [11:0] month_bits;
	logic [7:0]  wday_bits;

	match_t expected_runs[$];
	int     mismatches    = 0;
	int     starts_sent   = 0;
	int     runs_checked  = 0;
	int     found_runs    = 0;
	int     mask_settings = 0;
	int     quiet_cycles  = 0;
	int     stall_orders  = 0;
	int     stall_served  = 0;
	int     stall_left    = 0;
	bit     steady        = 0;

	always #2 clk = ~clk;

	function automatic int month_len(int y, int m);
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		if (m == 2) return leap ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
		return 31;
	endfunction

	// weekday of a Gregorian date; shift by 400 years keeps the year positive
	function automatic int week_day(int y, int m, int d);
		int offs[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
		int yy;
		if (m < 1 || m > 12) return 0;
		yy = y + 400 - ((m < 3) ? 1 : 0);
		return (yy + yy / 4 - yy / 100 + yy / 400 + offs[m - 1] + d) % 7;
	endfunction

	// classic cron day rule with the Sunday alias bit
	function automatic bit day_hit(int d, int wd);
		bit mday_wild, wday_wild, by_mday, by_wday;
		mday_wild = ($countones(mday_bits) == 31);
		wday_wild = ($countones(wday_bits) >= 7);
		by_mday   = mday_bits[d - 1];
		by_wday   = wday_bits[wd] || (wd == 0 && wday_bits[7]);
		if (mday_wild && wday_wild) return 1'b1;
		if (mday_wild) return by_wday;
		if (wday_wild) return by_mday;
		return by_mday || by_wday;
	endfunction

	// first matching minute at or after the start, within the year horizon
	function automatic match_t next_match(start_t s);
		int y, mo, d, h, mi, wd, lim, k;
		advance_t adv;
		match_t r;
		r   = '0;
		y   = s.year;
		lim = y + cnmt_pkg::HORIZON_YEARS;
		if (lim > cnmt_pkg::YEAR_CAP) lim = cnmt_pkg::YEAR_CAP;
		mo = s.month;
		if (mo < 1) mo = 1;
		if (mo > 12) mo = 12;
		d = s.day;
		if (d < 1) d = 1;
		if (d > month_len(y, mo)) d = month_len(y, mo);
		h  = (s.hour > 23) ? 23 : s.hour;
		mi = (s.minute > 59) ? 59 : s.minute;
		wd = (s.wday == 7) ? 0 : s.wday;
		adv = ADV_NONE;
		if (s.second != 0) begin
			if (mi >= 59) adv = ADV_HOUR;
			else mi++;
		end
		while (1) begin
			// apply the pending move, carrying into day and month
			if (adv == ADV_HOUR) begin
				mi = 0;
				if (h >= 23) adv = ADV_DAY;
				else begin
					h++;
					adv = ADV_NONE;
				end
			end
			if (adv == ADV_DAY) begin
				if (d >= month_len(y, mo)) adv = ADV_MONTH;
				else begin
					wd = (wd + 1) % 7;
					d++;
					h  = 0;
					mi = 0;
					adv = ADV_NONE;
				end
			end
			if (adv == ADV_MONTH) begin
				wd = (wd + month_len(y, mo) - d + 1) % 7;
				mo++;
				if (mo > 12) begin
					mo = 1;
					y++;
				end
				d  = 1;
				h  = 0;
				mi = 0;
			end
			adv = ADV_NONE;
			if (y >= lim) return r;

			if (!month_bits[mo - 1]) adv = ADV_MONTH;
			else if (!day_hit(d, wd)) adv = ADV_DAY;
			else begin
				k = h;
				while (k < 24 && !hour_bits[k]) k++;
				if (k >= 24) adv = ADV_DAY;
				else begin
					if (k != h) begin
						h  = k;
						mi = 0;
					end
					k = mi;
					while (k < 60 && !minute_bits[k]) k++;
					if (k >= 60) adv = ADV_HOUR;
					else begin
						r.found  = 1'b1;
						r.year   = y[11:0];
						r.month  = mo[3:0];
						r.day    = d[4:0];
						r.hour   = h[4:0];
						r.minute = k[5:0];
						r.wday   = wd[2:0];
						return r;
					end
				end
			end
		end
	endfunction

	function automatic start_t start_at(int y, int mo, int d, int h, int mi, int sec);
		start_t s;
		s.year   = 12'(y);
		s.month  = 4'(mo);
		s.day    = 5'(d);
		s.hour   = 5'(h);
		s.minute = 6'(mi);
		s.second = 6'(sec);
		s.wday   = 3'(week_day(y, mo, d));
		return s;
	endfunction

	function automatic logic [59:0] rnd60();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[59:0];
	endfunction

	// mostly well-formed dates, now and then out-of-range fields
	function automatic start_t random_start();
		start_t s;
		bit odd;
		odd = ($urandom_range(9) == 0);
		if ($urandom_range(9) == 0)
			s.year = $urandom_range(1) ? 12'($urandom_range(4080, 4095)) :
				12'($urandom_range(0, 40));
		else
			s.year = 12'($urandom_range(1970, 4000));
		s.month  = odd ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
		s.day    = odd ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(1, month_len(s.year, s.month)));
		s.hour   = odd ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
		s.minute = odd ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
		if ($urandom_range(1)) s.second = 6'd0;
		else s.second = odd ? 6'($urandom_range(1, 63)) : 6'($urandom_range(1, 59));
		s.wday = odd ? 3'($urandom_range(0, 7)) : 3'(week_day(s.year, s.month, s.day));
		return s;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// offer one start item, leave valid high after it is taken
	task automatic send_start(start_t s);
		if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			start_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start_ch.valid         <= 1'b1;
		start_ch.start_year    <= s.year;
		start_ch.start_month   <= s.month;
		start_ch.start_day     <= s.day;
		start_ch.start_hour    <= s.hour;
		start_ch.start_minute  <= s.minute;
		start_ch.start_second  <= s.second;
		start_ch.start_weekday <= s.wday;
		do @(posedge clk); while (!start_ch.ready);
		expected_runs.insert(expected_runs.size(), next_match(s));
		starts_sent++;
	endtask

	// write one mask register, leave valid high after the write
	task automatic write_reg(logic [cnmt_pkg::CFG_IDX_W-1:0] idx, logic [59:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			cnmt_pkg::CFG_MINUTE_MASK:  minute_bits = val[59:0];
			cnmt_pkg::CFG_HOUR_MASK:    hour_bits   = val[23:0];
			cnmt_pkg::CFG_MDAY_MASK:    mday_bits   = val[30:0];
			cnmt_pkg::CFG_MONTH_MASK:   month_bits  = val[11:0];
			cnmt_pkg::CFG_WEEKDAY_MASK: wday_bits   = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_masks(logic [59:0] mi, logic [59:0] hr, logic [59:0] md,
		logic [59:0] mo, logic [59:0] wd);
		write_reg(cnmt_pkg::CFG_MINUTE_MASK, mi);
		write_reg(cnmt_pkg::CFG_HOUR_MASK, hr);
		write_reg(cnmt_pkg::CFG_MDAY_MASK, md);
		write_reg(cnmt_pkg::CFG_MONTH_MASK, mo);
		write_reg(cnmt_pkg::CFG_WEEKDAY_MASK, wd);
		cfg_ch.valid <= 1'b0;
		mask_settings++;
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic wait_drain();
		start_ch.valid <= 1'b0;
		while (expected_runs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random mask set, junk above the width of each register but the minute one
	task automatic pick_masks();
		logic [59:0] mi, hr, md, mo, wd;
		case ($urandom_range(3))
			0: mi = '1;
			1: mi = rnd60();
			2: mi = 60'd1 << $urandom_range(59);
			default: mi = rnd60() & rnd60();
		endcase
		case ($urandom_range(3))
			0: hr = 60'hFFFFFF;
			1: hr = rnd60();
			2: hr = 60'd1 << $urandom_range(23);
			default: hr = rnd60() & rnd60();
		endcase
		case ($urandom_range(3))
			0: md = 60'h7FFFFFFF;
			1: md = rnd60();
			2: md = 60'd1 << $urandom_range(30);
			default: md = rnd60() | rnd60();
		endcase
		case ($urandom_range(3))
			0: mo = 60'hFFF;
			1: mo = rnd60();
			2: mo = 60'd1 << $urandom_range(11);
			default: mo = rnd60() | rnd60();
		endcase
		case ($urandom_range(3))
			0: wd = 60'h7F;
			1: wd = 60'hFF;
			2: wd = rnd60();
			default: wd = 60'h80;
		endcase
		set_masks(mi, (rnd60() & ~60'hFFFFFF) | hr[23:0], (rnd60() & ~60'h7FFFFFFF) | md[30:0],
			(rnd60() & ~60'hFFF) | mo[11:0], (rnd60() & ~60'hFF) | wd[7:0]);
	endtask

	task automatic test_calendar_edges();
		start_t s;
		wait_drain();
		set_masks('1, '1, '1, '1, 60'h7F);
		send_start(start_at(1970, 1, 1, 0, 0, 0));
		send_start(start_at(2023, 12, 31, 23, 59, 30));
		send_start(start_at(2024, 2, 28, 23, 59, 1));
		send_start(start_at(2023, 2, 28, 23, 59, 59));
		send_start(start_at(2100, 2, 28, 23, 59, 5));
		send_start(start_at(2000, 2, 28, 23, 59, 5));
		send_start(start_at(4095, 12, 31, 23, 59, 30));
		send_start(start_at(4095, 12, 31, 23, 59, 0));
		send_start(start_at(2024, 0, 15, 10, 20, 0));
		send_start(start_at(2024, 13, 15, 10, 20, 0));
		send_start(start_at(2024, 15, 31, 23, 59, 63));
		send_start(start_at(2024, 5, 0, 1, 2, 0));
		send_start(start_at(2023, 4, 31, 6, 30, 0));
		send_start(start_at(2023, 2, 31, 6, 30, 0));
		send_start(start_at(2024, 7, 4, 31, 10, 0));
		send_start(start_at(2024, 7, 4, 12, 63, 0));
		send_start(start_at(2024, 7, 4, 12, 63, 63));
		send_start(start_at(0, 2, 29, 23, 59, 45));
		// weekday seven stands for Sunday
		s = start_at(2024, 3, 10, 23, 59, 30);
		s.wday = 3'd7;
		send_start(s);
		// inconsistent weekday is carried forward as given
		s = start_at(2024, 3, 31, 23, 59, 30);
		s.wday = 3'd2;
		send_start(s);
	endtask

	task automatic test_day_rule();
		wait_drain();
		set_masks(60'd1 << 30, 60'd1 << 9, 60'd1 << 12, '1, 60'h7F);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
		send_start(start_at(2024, 1, 13, 9, 30, 1));
		wait_drain();
		set_masks('1, '1, 60'h7FFFFFFF, '1, 60'h20);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
		wait_drain();
		set_masks(60'd1, 60'd1, 60'd1 << 12, '1, 60'h20);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
		send_start(start_at(2024, 9, 6, 0, 0, 0));
		wait_drain();
		set_masks(60'd1 << 59, 60'd1 << 23, 60'd1 << 12, 60'd1 << 11, 60'hFF);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
		send_start(start_at(2024, 12, 13, 23, 59, 1));
	endtask

	task automatic test_sunday_alias();
		start_t s;
		wait_drain();
		set_masks('1, '1, 60'h7FFFFFFF, '1, 60'h80);
		send_start(start_at(2024, 6, 3, 5, 5, 0));
		s = start_at(2024, 6, 30, 23, 59, 10);
		s.wday = 3'd7;
		send_start(s);
		wait_drain();
		set_masks(60'd1, 60'd1, 60'd1 << 14, '1, 60'h81);
		send_start(start_at(2024, 6, 3, 5, 5, 0));
	endtask

	task automatic test_empty_masks();
		wait_drain();
		set_masks(60'd0, 60'd1 << 7, '1, '1, 60'h7F);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
		wait_drain();
		set_masks('1, 60'd0, '1, '1, 60'h7F);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
		wait_drain();
		set_masks('1, '1, 60'd0, '1, 60'h7F);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
		wait_drain();
		set_masks('1, '1, '1, 60'd0, 60'h7F);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
		wait_drain();
		set_masks('1, '1, 60'h7FFFFFFF, '1, 60'd0);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
		wait_drain();
		set_masks('1, '1, 60'd0, '1, 60'd0);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
	endtask

	// leap day, then February 30: reach across the horizon and the top year
	task automatic test_horizon();
		wait_drain();
		set_masks(60'd1, 60'd1, 60'd1 << 28, 60'd1 << 1, 60'd0);
		send_start(start_at(4090, 3, 1, 0, 0, 0));
		send_start(start_at(4093, 1, 1, 0, 0, 0));
		send_start(start_at(2097, 3, 1, 0, 0, 0));
		send_start(start_at(2096, 3, 1, 0, 0, 0));
		send_start(start_at(2096, 2, 29, 0, 0, 1));
		wait_drain();
		set_masks(60'd1, 60'd1, 60'd1 << 29, 60'd1 << 1, 60'd0);
		send_start(start_at(2024, 1, 1, 0, 0, 0));
	endtask

	task automatic test_spare_index();
		wait_drain();
		set_masks(60'd1 << 15, 60'h00F00F, 60'h0F0F0F0F, 60'hA5A, 60'h2A);
		for (int i = CFG_SPARE_FIRST; i < (1 << cnmt_pkg::CFG_IDX_W); i++)
			write_reg(i[cnmt_pkg::CFG_IDX_W-1:0], rnd60());
		cfg_ch.valid <= 1'b0;
		repeat (3) send_start(random_start());
	endtask

	// receiver stalls long while starts keep coming, then the sender drains
	task automatic test_backpressure();
		wait_drain();
		set_masks('1, '1, '1, '1, 60'h7F);
		steady       <= 1'b1;
		stall_orders <= stall_orders + 1;
		repeat (10) send_start(random_start());
		wait_drain();
		steady <= 1'b0;
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			wait_drain();
			pick_masks();
			steady <= (phase == 2);
			for (int n = 0; n < 8; n++) begin
				if (phase == 3 && n == 4) wait_drain();
				send_start(random_start());
			end
		end
		steady <= 1'b0;
	endtask

	// result ready: random idling, ordered long stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left      <= stall_left - 1;
			result_ch.ready <= 1'b0;
		end else if (stall_served != stall_orders) begin
			stall_served    <= stall_served + 1;
			stall_left      <= LONG_STALL;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// compare each result item with the oldest prediction
	always @(posedge clk) begin
		match_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_runs.size() == 0) begin
				$error("result item with no start pending");
				mismatches++;
			end else begin
				want = expected_runs.pop_front();
				check_field("found", want.found, result_ch.found);
				check_field("run_year", want.year, result_ch.run_year);
				check_field("run_month", want.month, result_ch.run_month);
				check_field("run_day", want.day, result_ch.run_day);
				check_field("run_hour", want.hour, result_ch.run_hour);
				check_field("run_minute", want.minute, result_ch.run_minute);
				check_field("run_weekday", want.wday, result_ch.run_weekday);
				runs_checked++;
				if (want.found) found_runs++;
			end
		end
	end

	// end the run when no channel moves for too long
	always @(posedge clk) begin
		if ((start_ch.valid && start_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("timeout: no item moved for %0d cycles", WATCHDOG_CYCLES);
			$display("tb_cron_next_match_time: done, errors");
			$finish;
		end
	end

	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		start_ch.valid         = 1'b0;
		start_ch.start_year    = '0;
		start_ch.start_month   = '0;
		start_ch.start_day     = '0;
		start_ch.start_hour    = '0;
		start_ch.start_minute  = '0;
		start_ch.start_second  = '0;
		start_ch.start_weekday = '0;
		result_ch.ready        = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = '0;
		cfg_ch.data            = '0;
		minute_bits            = '1;
		hour_bits              = '1;
		mday_bits              = '1;
		month_bits             = '1;
		wday_bits              = 8'h7F;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset masks first, untouched
		send_start(start_at(2024, 2, 29, 23, 59, 59));
		test_calendar_edges();
		test_day_rule();
		test_sunday_alias();
		test_empty_masks();
		test_horizon();
		test_spare_index();
		test_backpressure();
		test_random();
		wait_drain();

		$display("covered %0d start times over %0d mask settings", starts_sent, mask_settings);
		$display("checked %0d results, %0d with a match found", runs_checked, found_runs);
		if (mismatches == 0)
			$display("tb_cron_next_match_time: done, clean");
		else
			$display("tb_cron_next_match_time: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/cnmt_pkg.sv
rtl/cnmt_if.sv
rtl/cnmt_ctrl.sv
rtl/cnmt_dp.sv
rtl/cron_next_match_time.sv
verif/tb_cron_next_match_time.sv
